// File: rtl/rcks_pkg.sv
// Shared types, constants and helpers for the range code keypad sequencer.
// No dependencies; every other file of the block imports this package.
package rcks_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int MAX_DIGITS    = 8;

    localparam int CODE_W     = 27;
    localparam int ENTRY_W    = 7;
    localparam int DIGIT_W    = 4;
    localparam int DCOUNT_W   = 4;
    localparam int IDX_W      = $clog2(TABLE_ENTRIES);
    localparam int POS_W      = IDX_W + 1;
    localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_WRITE   = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    localparam logic [1:0] KEY_NONE    = 2'd0;
    localparam logic [1:0] KEY_PRESS   = 2'd1;
    localparam logic [1:0] KEY_OK      = 2'd2;
    localparam logic [1:0] KEY_RELEASE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OK_FORMAT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TICKS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_ENABLE = 3'd4;

    localparam logic [3:0] DIGIT_COUNT_RST   = 4'd5;
    localparam logic [1:0] OK_FORMAT_RST     = 2'd2;
    localparam logic [7:0] PRESS_TICKS_RST   = 8'd35;
    localparam logic [7:0] RELEASE_TICKS_RST = 8'd36;

    localparam logic [ENTRY_W-1:0] PREFIX_MAX = 7'd99;

    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    typedef enum logic [1:0] {
        ALU_INC,
        ALU_DEC,
        ALU_MUL10,
        ALU_DIV10
    } alu_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_START,
        ST_RD_END,
        ST_STEP,
        ST_PREFIX,
        ST_JUMP,
        ST_SCALE,
        ST_SPLIT_LD,
        ST_SPLIT,
        ST_FINISH
    } seq_state_t;

    typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digit_vec_t;

    typedef struct packed {
        logic [DCOUNT_W-1:0] digits;
        logic [1:0]          ok_format;
        logic [7:0]          press_ticks;
        logic [7:0]          release_ticks;
        logic                enable;
    } key_cfg_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [DIGIT_W-1:0] digit;
        logic               ready_clr;
    } key_res_t;

    function automatic logic [ENTRY_W-1:0] table_init(input int i);
        return (i < 8 && (i % 2) == 1) ? PREFIX_MAX : '0;
    endfunction

endpackage

// File: rtl/rcks_alu.sv
// Shared arithmetic unit: increment, decrement, multiply by ten, divide by ten.
// Division uses a reciprocal multiply; remainder comes from a shift-add subtract.
// Depends on rcks_pkg.
module rcks_alu (
    input  rcks_pkg::alu_op_t                   op,
    input  logic [rcks_pkg::CODE_W-1:0]         a,
    output logic [rcks_pkg::CODE_W-1:0]         y,
    output logic [rcks_pkg::DIGIT_W-1:0]        rem
);
    import rcks_pkg::*;

    logic [CODE_W+31:0] prod;
    logic [CODE_W-1:0]  quot;
    logic [CODE_W-1:0]  quot_x10;
    logic [CODE_W-1:0]  diff;

    assign prod     = (CODE_W+32)'(a) * (CODE_W+32)'(DIV10_RECIP);
    assign quot     = CODE_W'(prod >> DIV10_SHIFT);
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign diff     = a - quot_x10;
    assign rem      = diff[DIGIT_W-1:0];

    always_comb begin
        case (op)
            ALU_INC:   y = a + CODE_W'(1);
            ALU_DEC:   y = a - CODE_W'(1);
            ALU_MUL10: y = (a << 3) + (a << 1);
            ALU_DIV10: y = quot;
            default:   y = a;
        endcase
    end

endmodule

// File: rtl/rcks_keys.sv
// Key press timing: phase and hold counters that sequence digits, OK and releases.
// Advances once per step strobe. Depends on rcks_pkg.
module rcks_keys (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  rcks_pkg::key_cfg_t    cfg,
    input  rcks_pkg::digit_vec_t  digits,
    output rcks_pkg::key_res_t    res
);
    import rcks_pkg::*;

    logic [7:0] phase_reg, phase_next;
    logic [7:0] hold_reg, hold_next;
    logic [7:0] d8;
    logic [7:0] ph_inv;
    logic       skip_ok;

    assign d8     = 8'(cfg.digits);
    assign ph_inv = ~phase_reg;

    always_comb begin
        res        = '0;
        res.action = KEY_NONE;
        phase_next = phase_reg;
        hold_next  = hold_reg;
        skip_ok    = (cfg.ok_format == 2'd0) ||
                     (cfg.ok_format == 2'd1 && phase_reg == d8 + 8'd1);
        if (cfg.enable) begin
            if (hold_reg != 8'd0) begin
                hold_next = hold_reg - 8'd1;
            end else if (phase_reg < d8) begin
                res.action = KEY_PRESS;
                res.digit  = digits[phase_reg[DIG_IDX_W-1:0]];
                phase_next = ph_inv;
                hold_next  = cfg.press_ticks;
            end else if (phase_reg == d8 || phase_reg == d8 + 8'd1) begin
                res.action = skip_ok ? KEY_NONE : KEY_OK;
                phase_next = ph_inv;
                hold_next  = cfg.press_ticks;
            end else if (phase_reg > 8'd255 - d8 - 8'd2) begin
                res.action    = KEY_RELEASE;
                res.ready_clr = (ph_inv == d8 - 8'd1);
                phase_next    = ph_inv + 8'd1;
                hold_next     = cfg.release_ticks;
            end else begin
                phase_next = 8'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 8'd0;
            hold_reg  <= 8'd0;
        end else if (step) begin
            phase_reg <= phase_next;
            hold_reg  <= hold_next;
        end
    end

endmodule

// File: rtl/range_code_keypad_sequencer.sv
// Range code keypad sequencer top level: handshake, configuration, range table,
// code sequencer around the shared arithmetic unit, and the key timing block.
// Write and unused requests and ticks with a ready code go straight to the result;
// restart runs multiply-by-ten steps; a tick that advances the code runs the
// divide-by-ten and multiply-by-ten steps of the shared unit. One transfer at a
// time: the next item is taken the cycle after the result is registered. The
// synchronous active-low reset restores the table and all but the datapath registers.
module range_code_keypad_sequencer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_req_type,
    input  logic [3:0]                         s_entry_index,
    input  logic [rcks_pkg::ENTRY_W-1:0]       s_entry_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_key_action,
    output logic [rcks_pkg::DIGIT_W-1:0]       m_key_digit,
    input  logic                               cfg_wr_en,
    input  logic [rcks_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rcks_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import rcks_pkg::*;

    seq_state_t state_reg, state_next;

    logic [DCOUNT_W-1:0] digit_count_reg;
    logic [1:0]          ok_format_reg;
    logic [7:0]          press_ticks_reg;
    logic [7:0]          release_ticks_reg;
    logic                output_enable_reg;

    logic [ENTRY_W-1:0]  table_reg [TABLE_ENTRIES];

    logic [CODE_W-1:0]   code_reg, code_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    digit_vec_t          digits_reg, digits_next;
    logic                code_ready_reg, code_ready_next;
    logic                tick_reg, tick_next;
    logic                m_valid_reg, m_valid_next;
    logic [1:0]          m_action_reg, m_action_next;
    logic [DIGIT_W-1:0]  m_digit_reg, m_digit_next;

    logic [CODE_W-1:0]   work_reg, work_next;
    logic [ENTRY_W-1:0]  start_reg, start_next;
    logic [ENTRY_W-1:0]  end_reg, end_next;
    logic                down_reg, down_next;
    logic [DIG_IDX_W-1:0] cnt_reg, cnt_next;
    logic [DIG_IDX_W-1:0] sidx_reg, sidx_next;

    logic [DCOUNT_W-1:0] d_eff;
    logic [DIG_IDX_W-1:0] scale_init;
    logic                accept;
    logic                out_free;
    logic                tbl_we;
    logic [POS_W-1:0]    rd_addr;
    logic [ENTRY_W-1:0]  rd_data;
    logic                need_jump;

    alu_op_t             alu_op;
    logic [CODE_W-1:0]   alu_a;
    logic [CODE_W-1:0]   alu_y;
    logic [DIGIT_W-1:0]  alu_rem;

    key_cfg_t            key_cfg;
    key_res_t            key_res;
    logic                key_step;

    assign d_eff = (digit_count_reg < 4'd2) ? 4'd2 :
                   (digit_count_reg > DCOUNT_W'(MAX_DIGITS)) ? DCOUNT_W'(MAX_DIGITS) :
                   digit_count_reg;
    assign scale_init = DIG_IDX_W'(d_eff - 4'd2);

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign tbl_we   = accept && s_req_type == REQ_WRITE &&
                      32'(s_entry_index) < 32'(TABLE_ENTRIES);

    assign m_valid      = m_valid_reg;
    assign m_key_action = m_action_reg;
    assign m_key_digit  = m_digit_reg;

    assign rd_data = (rd_addr < POS_W'(TABLE_ENTRIES)) ? table_reg[rd_addr[IDX_W-1:0]] : '0;
    assign need_jump = down_reg ? (work_reg[7:0] <  8'(end_reg)) :
                                  (work_reg[7:0] >= 8'(end_reg));

    assign key_cfg.digits        = d_eff;
    assign key_cfg.ok_format     = ok_format_reg;
    assign key_cfg.press_ticks   = press_ticks_reg;
    assign key_cfg.release_ticks = release_ticks_reg;
    assign key_cfg.enable        = output_enable_reg;
    assign key_step = (state_reg == ST_FINISH) && out_free && tick_reg;

    rcks_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .y   (alu_y),
        .rem (alu_rem)
    );

    rcks_keys u_keys (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (key_step),
        .cfg     (key_cfg),
        .digits  (digits_reg),
        .res     (key_res)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_req_type)
                        REQ_TICK:    state_next = code_ready_reg ? ST_FINISH : ST_RD_START;
                        REQ_RESTART: state_next = ST_SCALE;
                        default:     state_next = ST_FINISH;
                    endcase
                end
            end
            ST_RD_START: begin
                state_next = (pos_reg >= POS_W'(TABLE_ENTRIES)) ? ST_FINISH : ST_RD_END;
            end
            ST_RD_END: state_next = ST_STEP;
            ST_STEP: begin
                if (start_reg == '0 && end_reg == '0) begin
                    state_next = ST_FINISH;
                end else if (start_reg == end_reg) begin
                    state_next = ST_SPLIT_LD;
                end else begin
                    state_next = ST_PREFIX;
                end
            end
            ST_PREFIX: begin
                if (cnt_reg == '0) begin
                    state_next = need_jump ? ST_JUMP : ST_SPLIT_LD;
                end
            end
            ST_JUMP: state_next = ST_SCALE;
            ST_SCALE: begin
                if (cnt_reg == '0) begin
                    state_next = tick_reg ? ST_SPLIT_LD : ST_FINISH;
                end
            end
            ST_SPLIT_LD: state_next = ST_SPLIT;
            ST_SPLIT: begin
                if (sidx_reg == '0) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        alu_op          = ALU_DIV10;
        alu_a           = work_reg;
        rd_addr         = pos_reg;
        code_next       = code_reg;
        pos_next        = pos_reg;
        digits_next     = digits_reg;
        code_ready_next = code_ready_reg;
        tick_next       = tick_reg;
        work_next       = work_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        down_next       = down_reg;
        cnt_next        = cnt_reg;
        sidx_next       = sidx_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_action_next   = m_action_reg;
        m_digit_next    = m_digit_reg;
        unique case (state_reg)
            ST_IDLE: begin
                rd_addr = '0;
                if (accept) begin
                    tick_next = (s_req_type == REQ_TICK);
                    if (s_req_type == REQ_TICK) begin
                        code_ready_next = 1'b1;
                    end
                    if (s_req_type == REQ_RESTART) begin
                        pos_next  = '0;
                        code_next = CODE_W'(rd_data);
                        cnt_next  = scale_init;
                    end
                end
            end
            ST_RD_START: start_next = rd_data;
            ST_RD_END: begin
                rd_addr  = pos_reg + POS_W'(1);
                end_next = rd_data;
            end
            ST_STEP: begin
                alu_op    = (start_reg > end_reg) ? ALU_DEC : ALU_INC;
                alu_a     = code_reg;
                down_next = (start_reg > end_reg);
                work_next = alu_y;
                cnt_next  = scale_init;
                if (start_reg != end_reg) begin
                    code_next = alu_y;
                end
            end
            ST_PREFIX: begin
                if (cnt_reg != '0) begin
                    work_next = alu_y;
                    cnt_next  = cnt_reg - DIG_IDX_W'(1);
                end else if (need_jump) begin
                    pos_next = pos_reg + POS_W'(2);
                end
            end
            ST_JUMP: begin
                code_next = CODE_W'(rd_data);
                cnt_next  = scale_init;
            end
            ST_SCALE: begin
                alu_op = ALU_MUL10;
                alu_a  = code_reg;
                if (cnt_reg != '0) begin
                    code_next = alu_y;
                    cnt_next  = cnt_reg - DIG_IDX_W'(1);
                end
            end
            ST_SPLIT_LD: begin
                work_next = code_reg;
                sidx_next = DIG_IDX_W'(d_eff - 4'd1);
            end
            ST_SPLIT: begin
                digits_next[sidx_reg] = alu_rem;
                work_next             = alu_y;
                sidx_next             = sidx_reg - DIG_IDX_W'(1);
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_action_next = tick_reg ? key_res.action : KEY_NONE;
                    m_digit_next  = tick_reg ? key_res.digit : '0;
                    if (key_step && key_res.ready_clr) begin
                        code_ready_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_count_reg   <= DIGIT_COUNT_RST;
            ok_format_reg     <= OK_FORMAT_RST;
            press_ticks_reg   <= PRESS_TICKS_RST;
            release_ticks_reg <= RELEASE_TICKS_RST;
            output_enable_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DIGIT_COUNT:   digit_count_reg   <= cfg_data[DCOUNT_W-1:0];
                CFG_OK_FORMAT:     ok_format_reg     <= cfg_data[1:0];
                CFG_PRESS_TICKS:   press_ticks_reg   <= cfg_data;
                CFG_RELEASE_TICKS: release_ticks_reg <= cfg_data;
                CFG_OUTPUT_ENABLE: output_enable_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                table_reg[i] <= table_init(i);
            end
        end else if (tbl_we) begin
            table_reg[IDX_W'(s_entry_index)] <= s_entry_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            code_reg       <= '0;
            pos_reg        <= '0;
            digits_reg     <= '0;
            code_ready_reg <= 1'b0;
            tick_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_action_reg   <= KEY_NONE;
            m_digit_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            code_reg       <= code_next;
            pos_reg        <= pos_next;
            digits_reg     <= digits_next;
            code_ready_reg <= code_ready_next;
            tick_reg       <= tick_next;
            m_valid_reg    <= m_valid_next;
            m_action_reg   <= m_action_next;
            m_digit_reg    <= m_digit_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg  <= work_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        down_reg  <= down_next;
        cnt_reg   <= cnt_next;
        sidx_reg  <= sidx_next;
    end

endmodule

// File: rtl/rcks_checker.sv
// Port-level checks for the range code keypad sequencer, bound to the top level.
// Depends on rcks_pkg and range_code_keypad_sequencer.
module rcks_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic [1:0]                         s_req_type,
    input logic [3:0]                         s_entry_index,
    input logic [rcks_pkg::ENTRY_W-1:0]       s_entry_value,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [1:0]                         m_key_action,
    input logic [rcks_pkg::DIGIT_W-1:0]       m_key_digit,
    input logic                               cfg_wr_en,
    input logic [rcks_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic [rcks_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import rcks_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_key_action) && $stable(m_key_digit))
        else $error("result changed while stalled");

    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a transfer");

    a_digit_only_on_press: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_key_action != KEY_PRESS |-> m_key_digit == '0)
        else $error("digit set without a digit press");

    a_digit_decimal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_key_digit <= DIGIT_W'(9))
        else $error("digit out of decimal range");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind range_code_keypad_sequencer rcks_checker u_rcks_checker (.*);
